@@ rtl/core/wsfp_pkg.sv @@
// Shared constants and the per-beat result type of the websocket frame parser.
// No dependencies.
`default_nettype none

package wsfp_pkg;

  localparam int unsigned LenBits = 64;

  localparam logic [6:0] Len7Is16  = 7'd126;
  localparam logic [6:0] Len7Is64  = 7'd127;
  localparam logic [3:0] XlenCnt16 = 4'd2;
  localparam logic [3:0] XlenCnt64 = 4'd8;
  localparam logic [3:0] OpcClose  = 4'h8;
  localparam logic [3:0] OpcBinary = 4'h2;

  localparam int unsigned OutDataBits = 80;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic [3:0]  frame_opcode;
    logic        final_fragment;
    logic        binary_frame;
    logic [63:0] frame_length;
    logic        link_closed;
  } wsfp_result_t;

endpackage

`default_nettype wire

@@ rtl/core/wsfp_core.sv @@
// Frame header walker and payload unmasker: holds the parse state and
// computes the result of one stream byte. Depends on wsfp_pkg.
`default_nettype none

module wsfp_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output wsfp_pkg::wsfp_result_t res_o
);
  import wsfp_pkg::*;

  typedef enum logic [2:0] {
    PhHdr0,
    PhHdr1,
    PhXlen,
    PhMask,
    PhData
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [3:0]           lbytes_q, lbytes_d;
  logic [LenBits-1:0]   total_q, total_d;
  logic [LenBits-1:0]   left_q, left_d;
  logic [3:0][7:0]      key_q, key_d;
  logic [1:0]           mpos_q, mpos_d;
  logic                 masked_q, masked_d;
  logic [3:0]           opc_q, opc_d;
  logic                 final_q, final_d;
  logic                 closed_q, closed_d;
  logic                 hdr_done;
  logic                 frame_end;
  wsfp_result_t         res;

  always_comb begin
    phase_d   = phase_q;
    lbytes_d  = lbytes_q;
    total_d   = total_q;
    left_d    = left_q;
    key_d     = key_q;
    mpos_d    = mpos_q;
    masked_d  = masked_q;
    opc_d     = opc_q;
    final_d   = final_q;
    closed_d  = closed_q;
    hdr_done  = 1'b0;
    frame_end = 1'b0;
    res       = '0;

    if (closed_q) begin
      res.link_closed = 1'b1;
    end else begin
      case (phase_q)
        PhHdr0: begin
          final_d = byte_i[7];
          opc_d   = byte_i[3:0];
          phase_d = PhHdr1;
        end
        PhHdr1: begin
          masked_d = byte_i[7];
          if (byte_i[6:0] inside {Len7Is16, Len7Is64}) begin
            total_d  = '0;
            lbytes_d = (byte_i[6:0] == Len7Is16) ? XlenCnt16 : XlenCnt64;
            phase_d  = PhXlen;
          end else begin
            total_d  = LenBits'(byte_i[6:0]);
            hdr_done = 1'b1;
          end
        end
        PhXlen: begin
          total_d = {total_q[LenBits-9:0], byte_i};
          if (lbytes_q <= 4'd1) begin
            lbytes_d = '0;
            hdr_done = 1'b1;
          end else begin
            lbytes_d = lbytes_q - 4'd1;
          end
        end
        PhMask: begin
          key_d[mpos_q] = byte_i;
          mpos_d        = mpos_q + 2'd1;
          if (mpos_q == 2'd3) begin
            if (left_q == '0) begin
              frame_end = 1'b1;
            end else begin
              phase_d = PhData;
            end
          end
        end
        PhData: begin
          if (left_q == '0) begin
            frame_end = 1'b1;
          end else begin
            res.data_valid   = 1'b1;
            res.payload_byte = masked_q ? (byte_i ^ key_q[mpos_q]) : byte_i;
            mpos_d           = mpos_q + 2'd1;
            left_d           = left_q - LenBits'(1);
            frame_end        = (left_q == LenBits'(1));
          end
        end
        default: begin
          phase_d = PhHdr0;
        end
      endcase

      if (hdr_done) begin
        left_d = total_d;
        mpos_d = '0;
        if (masked_d) begin
          phase_d = PhMask;
        end else if (total_d == '0) begin
          frame_end = 1'b1;
        end else begin
          phase_d = PhData;
        end
      end

      res.frame_end      = frame_end;
      res.frame_opcode   = opc_d;
      res.final_fragment = final_d;
      res.binary_frame   = (opc_d == OpcBinary);
      res.frame_length   = 64'(total_d);

      if (frame_end) begin
        if (opc_d == OpcClose) begin
          closed_d = 1'b1;
        end
        phase_d  = PhHdr0;
        total_d  = '0;
        left_d   = '0;
        lbytes_d = '0;
        mpos_d   = '0;
      end
      res.link_closed = closed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr0;
      lbytes_q <= '0;
      total_q  <= '0;
      left_q   <= '0;
      key_q    <= '0;
      mpos_q   <= '0;
      masked_q <= 1'b0;
      opc_q    <= '0;
      final_q  <= 1'b0;
      closed_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      lbytes_q <= lbytes_d;
      total_q  <= total_d;
      left_q   <= left_d;
      key_q    <= key_d;
      mpos_q   <= mpos_d;
      masked_q <= masked_d;
      opc_q    <= opc_d;
      final_q  <= final_d;
      closed_q <= closed_d;
    end
  end

  assign res_o = res;

  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |=> closed_q)
    else $error("closed flag dropped");

  a_closed_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(closed_q) |-> $past(step_i) && $past(res.frame_end))
    else $error("link closed without a completed frame");

  a_data_has_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData |-> left_q != '0)
    else $error("payload phase with no bytes left");

endmodule

`default_nettype wire

@@ rtl/core/websocket_frame_parser_unit.sv @@
// Top level of the websocket frame parser: stream ports, parse core and
// output register. Depends on wsfp_pkg and wsfp_core.
// Each accepted input beat gives its result beat from the output register in the next cycle.
// Throughput: one byte per cycle; the single output register takes a new
// result whenever it is empty or its beat is taken in the same cycle.
// Reset: rst_ni clears the parse state, the closed flag and the output valid.
`default_nettype none

module websocket_frame_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [11:8] frame_opcode, [12] final_fragment,
  // [13] binary_frame, [77:14] frame_length, [78] link_closed, [79] zero
  output logic [wsfp_pkg::OutDataBits-1:0] m_axis_tdata,
  output logic        m_axis_tlast,  // frame_end
  output logic        m_axis_tuser   // data_valid
);
  import wsfp_pkg::*;

  logic         step;
  logic         out_valid_q;
  wsfp_result_t res;
  wsfp_result_t res_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  wsfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s_axis_tdata),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.link_closed, res_q.frame_length, res_q.binary_frame,
                          res_q.final_fragment, res_q.frame_opcode, res_q.payload_byte};
  assign m_axis_tlast  = res_q.frame_end;
  assign m_axis_tuser  = res_q.data_valid;

  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

endmodule

`default_nettype wire
